// ----- src/keypad_code_lock_core_defines.svh -----
// keypad_code_lock_core_defines.svh: assertion macros for the code lock checker.
// Depends on nothing; included by the checker file only.
`ifndef KEYPAD_CODE_LOCK_CORE_DEFINES_SVH
`define KEYPAD_CODE_LOCK_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KCL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KCL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/kcl_pkg.sv -----
// kcl_pkg: types, codes and reset constants of the keypad code lock.
// Depends on nothing; used by kcl_step, keypad_code_lock_core and kcl_checker.
package kcl_pkg;

    localparam int KCL_CODE_LENGTH = 6;

    localparam int CODE_W    = 24;
    localparam int TIMEOUT_W = 16;
    localparam int KEY_W     = 4;
    localparam int STATUS_W  = 3;
    localparam int EPOS_W    = 3;
    localparam int IN_DATA_W  = 8;   // key_code padded to a byte
    localparam int OUT_DATA_W = 16;  // status, echo_position, echo_digit padded
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [CODE_W-1:0]    STORED_CODE_RESET = 24'h443102;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET     = 16'd60000;
    localparam logic [KEY_W-1:0]     DIGIT_MAX         = 4'd9;

    // Input kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_KEY  = 1'b1;

    // Register word index (paddr[2])
    localparam logic REG_STORED_CODE = 1'b0;
    localparam logic REG_TIMEOUT     = 1'b1;

    typedef logic [STATUS_W-1:0] kcl_status_t;

    localparam kcl_status_t ST_NONE     = 3'd0;
    localparam kcl_status_t ST_DIGIT    = 3'd1;
    localparam kcl_status_t ST_UNLOCKED = 3'd2;
    localparam kcl_status_t ST_DENIED   = 3'd3;
    localparam kcl_status_t ST_TIMEOUT  = 3'd4;

    typedef struct packed {
        logic [KEY_W-1:0]  echo_digit;
        logic [EPOS_W-1:0] echo_position;
        kcl_status_t       status;
    } kcl_result_t;

    typedef struct packed {
        logic                 entering;
        logic                 digit_we;
        logic [TIMEOUT_W-1:0] idle_count;
    } kcl_update_t;

endpackage

// ----- src/keypad_code_lock_core.sv -----
// Keypad code lock core: a request passes the input register, then the result
// register, before m_tvalid; throughput one request per cycle while m_tready keeps
// up, as the entry state (position, idle counter, flag) updates once per request.
// Reset (rst_n low, asynchronous) empties both stages, returns to idle with
// position and idle counter zero, and loads the register reset values; the
// digit store is not reset.
// Depends on kcl_pkg and kcl_step.
module keypad_code_lock_core #(
    parameter int CODE_LENGTH = kcl_pkg::KCL_CODE_LENGTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request stream in
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [kcl_pkg::IN_DATA_W-1:0]   s_tdata,   // [3:0] key_code, [7:4] zero
    input  logic                            s_tuser,   // [0] kind
    // result stream out
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [kcl_pkg::OUT_DATA_W-1:0]  m_tdata,   // [2:0] status, [5:3] echo_position,
                                                       // [9:6] echo_digit, [15:10] zero
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [kcl_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [kcl_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [kcl_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import kcl_pkg::*;

    localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

    // Configuration registers
    logic [CODE_W-1:0]    stored_code_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic                 cfg_write;

    // Input stage
    logic             in_valid_reg;
    logic             in_kind_reg;
    logic [KEY_W-1:0] in_key_reg;

    // Entry state
    logic                     entering_reg;
    logic [IDX_W-1:0]         position_reg;
    logic [TIMEOUT_W-1:0]     idle_count_reg;
    logic [4*CODE_LENGTH-1:0] digits_reg;

    // Result stage
    logic        out_valid_reg;
    kcl_result_t out_data_reg;

    logic             advance;
    logic             fire;
    logic [IDX_W-1:0] wr_index;
    logic [IDX_W-1:0] position_next;
    kcl_update_t      update;
    kcl_result_t      result;

    // ------------------------------------------------------------------
    // APB: pready is tied high, a write lands on the access phase.
    // Decode on the word index; byte lanes inside a word are not decoded.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_code_reg <= STORED_CODE_RESET;
            timeout_reg     <= TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_STORED_CODE: stored_code_reg <= pwdata[CODE_W-1:0];
                REG_TIMEOUT:     timeout_reg     <= pwdata[TIMEOUT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_STORED_CODE: prdata = {{(APB_DATA_W - CODE_W){1'b0}}, stored_code_reg};
            REG_TIMEOUT:     prdata = {{(APB_DATA_W - TIMEOUT_W){1'b0}}, timeout_reg};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: the result register frees whenever it is empty or taken,
    // and the input register refills in the same cycle it drains, so one
    // request per cycle flows while the consumer keeps up.
    // ------------------------------------------------------------------
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    // Payload: hold while stalled, capture on every accepted request.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_kind_reg <= s_tuser;
            in_key_reg  <= s_tdata[KEY_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Evaluation of the request held in the input register
    // ------------------------------------------------------------------
    kcl_step #(
        .CODE_LENGTH (CODE_LENGTH),
        .IDX_W       (IDX_W)
    ) u_step (
        .kind          (in_kind_reg),
        .key_code      (in_key_reg),
        .entering      (entering_reg),
        .position      (position_reg),
        .idle_count    (idle_count_reg),
        .digits        (digits_reg),
        .stored_code   (stored_code_reg),
        .timeout_ticks (timeout_reg),
        .wr_index      (wr_index),
        .position_next (position_next),
        .update        (update),
        .result        (result)
    );

    // Advance the entry state only when the request moves on to the result stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entering_reg   <= 1'b0;
            position_reg   <= '0;
            idle_count_reg <= '0;
        end
        else if (fire)
        begin
            entering_reg   <= update.entering;
            position_reg   <= position_next;
            idle_count_reg <= update.idle_count;
        end
    end

    // Digit store: written only at positions of the current entry.
    always_ff @(posedge clk)
    begin
        if (fire && update.digit_we)
            digits_reg[wr_index*4 +: 4] <= in_key_reg;
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_data_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - $bits(kcl_result_t)){1'b0}}, out_data_reg};

endmodule

// ----- src/kcl_step.sv -----
// kcl_step: combinational per-request evaluation of the code lock.
// Depends on kcl_pkg; instantiated by keypad_code_lock_core.
module kcl_step #(
    parameter int CODE_LENGTH = kcl_pkg::KCL_CODE_LENGTH,
    parameter int IDX_W       = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1
) (
    input  logic                         kind,
    input  logic [kcl_pkg::KEY_W-1:0]    key_code,
    input  logic                         entering,
    input  logic [IDX_W-1:0]             position,
    input  logic [kcl_pkg::TIMEOUT_W-1:0] idle_count,
    input  logic [4*CODE_LENGTH-1:0]     digits,
    input  logic [kcl_pkg::CODE_W-1:0]   stored_code,
    input  logic [kcl_pkg::TIMEOUT_W-1:0] timeout_ticks,
    output logic [IDX_W-1:0]             wr_index,
    output logic [IDX_W-1:0]             position_next,
    output kcl_pkg::kcl_update_t         update,
    output kcl_pkg::kcl_result_t         result
);
    import kcl_pkg::*;

    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(CODE_LENGTH - 1);

    logic [IDX_W-1:0]     cur_pos;
    logic                 last_digit;
    logic                 is_digit;
    logic                 mismatch;
    logic [63:0]          code_ext;
    logic [KEY_W-1:0]     entered;
    logic [KEY_W-1:0]     expected;
    logic [TIMEOUT_W-1:0] count_inc;

    // A new entry always starts at the first position.
    assign cur_pos    = entering ? position : '0;
    assign last_digit = (cur_pos == LAST_POS);
    assign is_digit   = (kind == KIND_KEY) && (key_code <= DIGIT_MAX);
    assign code_ext   = {{(64 - CODE_W){1'b0}}, stored_code};
    assign count_inc  = (idle_count == '1) ? idle_count : idle_count + 16'd1;
    assign wr_index   = cur_pos;

    // Compare the whole entry; the final digit comes straight from the key.
    always_comb
    begin
        mismatch = 1'b0;
        entered  = '0;
        expected = '0;
        for (int k = 0; k < CODE_LENGTH; k++)
        begin
            entered  = (k == CODE_LENGTH - 1) ? key_code : digits[4*k +: 4];
            expected = code_ext[4*(CODE_LENGTH-1-k) +: 4];
            if (entered != expected)
                mismatch = 1'b1;
        end
    end

    always_comb
    begin
        result               = '0;
        update.entering      = entering;
        update.digit_we      = 1'b0;
        update.idle_count    = idle_count;
        position_next        = position;
        if (is_digit)
        begin
            update.digit_we      = 1'b1;
            update.idle_count    = '0;
            result.echo_position = EPOS_W'(cur_pos);
            result.echo_digit    = key_code;
            if (last_digit)
            begin
                result.status   = mismatch ? ST_DENIED : ST_UNLOCKED;
                update.entering = 1'b0;
                position_next   = '0;
            end
            else
            begin
                result.status   = ST_DIGIT;
                update.entering = 1'b1;
                position_next   = IDX_W'(cur_pos + 1'b1);
            end
        end
        else if ((kind == KIND_TICK) && entering)
        begin
            update.idle_count = count_inc;
            if (count_inc >= timeout_ticks)
            begin
                result.status     = ST_TIMEOUT;
                update.entering   = 1'b0;
                update.idle_count = '0;
                position_next     = '0;
            end
        end
    end

endmodule

// ----- src/kcl_checker.sv -----
// kcl_checker: port-level assertions for keypad_code_lock_core, bound to it below.
// Depends on kcl_pkg and keypad_code_lock_core_defines.svh.
`include "keypad_code_lock_core_defines.svh"

module kcl_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [kcl_pkg::OUT_DATA_W-1:0] m_tdata
);
    import kcl_pkg::*;

    logic [STATUS_W-1:0] out_status;
    logic                status_legal;
    logic                echo_zero_case;

    assign out_status     = m_tdata[2:0];
    assign status_legal   = (out_status == ST_NONE) || (out_status == ST_DIGIT) ||
                            (out_status == ST_UNLOCKED) || (out_status == ST_DENIED) ||
                            (out_status == ST_TIMEOUT);
    assign echo_zero_case = (out_status == ST_NONE) || (out_status == ST_TIMEOUT);

    // A stalled result keeps its value.
    `KCL_ASSERT_NXT(a_hold_stalled, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
    // With the result stage empty, the input side must take a request.
    `KCL_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !m_tvalid, s_tready, "input not ready with empty result stage")
    // Only defined status codes leave the block.
    `KCL_ASSERT_IMP(a_status_legal, clk, rst_n, m_tvalid, status_legal, "undefined status code")
    // No digit echo on a result without a digit.
    `KCL_ASSERT_IMP(a_echo_zero, clk, rst_n, m_tvalid && echo_zero_case, m_tdata[OUT_DATA_W-1:3] == '0, "echo fields set without a digit")

endmodule

bind keypad_code_lock_core kcl_checker u_kcl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
